// ===== hdl/mpq_pkg.sv =====
`default_nettype none

package mpq_pkg;

  // Heap geometry
  localparam int HEAP_DEPTH = 16;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  // child index math needs room for 2*pos+2
  localparam int POS_W      = IDX_W + 2;

  // Field widths
  localparam int VAL_W = 32;
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;
  localparam int CFG_W = 5;
  localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

`default_nettype wire

// ===== hdl/max_priority_queue_core.sv =====
`default_nettype none

// Binary max-heap held in a two-read, one-write RAM; the root is mirrored in a register.
// No sift: peek, empty, overflow, unused code, insert into an empty heap, extract of the only entry.
// Insert: sifts up with one RAM read/compare per level climbed.
// Extract: moves the last entry to the root, then a read state and a compare state per level descended.
// busy is high until the result strobe; results cannot be stalled. Reset clears the count,
// the controller and the capacity (16); RAM contents need no clearing.
module max_priority_queue_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [mpq_pkg::CMD_W-1:0]         command_i,
  input  wire logic signed [mpq_pkg::VAL_W-1:0]  value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [mpq_pkg::CFG_W-1:0]         cfg_wdata_i,
  output      logic                              done_o,
  output      logic signed [mpq_pkg::VAL_W-1:0]  result_value_o,
  output      logic [mpq_pkg::ST_W-1:0]          status_o,
  output      logic [mpq_pkg::CNT_W-1:0]         entry_total_o
);

  localparam int IDX_W = mpq_pkg::IDX_W;
  localparam int CNT_W = mpq_pkg::CNT_W;
  localparam int POS_W = mpq_pkg::POS_W;
  localparam int VAL_W = mpq_pkg::VAL_W;
  localparam int CAP_W = mpq_pkg::CAP_W;

  // Controller states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_CMP  = 3'd1;
  localparam logic [2:0] S_UP_FIN  = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [mpq_pkg::CFG_W-1:0]      cfg_q;
  logic [IDX_W-1:0]               pos_q, pos_d;
  logic signed [VAL_W-1:0]        val_q, val_d;
  logic signed [VAL_W-1:0]        root_q, root_d;
  logic                           done_q, done_d;
  logic signed [VAL_W-1:0]        res_q, res_d;
  logic [mpq_pkg::ST_W-1:0]       st_q, st_d;
  logic [CNT_W-1:0]               tot_q, tot_d;

  // RAM port signals
  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic signed [VAL_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]               ram_raddr_a, ram_raddr_b;
  logic signed [VAL_W-1:0]        ram_rdata_a, ram_rdata_b;

  mpq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (mpq_pkg::HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // Effective capacity: register limited to the depth
  logic [CAP_W-1:0] cap_reg, cap_eff;
  logic             heap_full;
  assign cap_reg   = CAP_W'(cfg_q);
  assign cap_eff   = (cap_reg > CAP_W'(mpq_pkg::HEAP_DEPTH)) ?
                     CAP_W'(mpq_pkg::HEAP_DEPTH) : cap_reg;
  assign heap_full = CAP_W'(count_q) >= cap_eff;

  // Tree index helpers
  logic [IDX_W-1:0] up_idx, ins_idx, ins_up;
  logic [POS_W-1:0] left_idx, right_idx, n_ext;
  logic             left_ok, right_ok, take_right;
  logic signed [VAL_W-1:0] child_val;
  logic [IDX_W-1:0] child_idx;

  assign up_idx     = (pos_q - IDX_W'(1)) >> 1;
  assign ins_idx    = IDX_W'(count_q);
  assign ins_up     = (ins_idx - IDX_W'(1)) >> 1;
  assign left_idx   = POS_W'({pos_q, 1'b1});
  assign right_idx  = left_idx + POS_W'(1);
  assign n_ext      = POS_W'(count_q);
  assign left_ok    = left_idx < n_ext;
  assign right_ok   = right_idx < n_ext;
  // left child wins a tie
  assign take_right = right_ok && (ram_rdata_b > ram_rdata_a);
  assign child_val  = take_right ? ram_rdata_b : ram_rdata_a;
  assign child_idx  = take_right ? IDX_W'(right_idx) : IDX_W'(left_idx);

  assign busy = state_q != S_IDLE;

  // Command sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    root_d      = root_q;
    done_d      = 1'b0;
    res_d       = res_q;
    st_d        = st_q;
    tot_d       = tot_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = val_q;
    ram_raddr_a = ins_up;
    ram_raddr_b = ins_up;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d = '0;
          st_d  = mpq_pkg::ST_OK;
          tot_d = count_q;
          unique case (command_i) inside
            mpq_pkg::CMD_INSERT: begin
              if (heap_full) begin
                st_d   = mpq_pkg::ST_OVERFLOW;
                done_d = 1'b1;
              end else begin
                count_d = count_q + CNT_W'(1);
                tot_d   = count_q + CNT_W'(1);
                val_d   = value_i;
                pos_d   = ins_idx;
                if (count_q == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = value_i;
                  done_d    = 1'b1;
                end else begin
                  ram_raddr_a = ins_up;
                  state_d     = S_UP_CMP;
                end
              end
            end
            mpq_pkg::CMD_EXTRACT, mpq_pkg::CMD_PEEK: begin
              if (count_q == '0) begin
                res_d  = mpq_pkg::EMPTY_VALUE;
                st_d   = mpq_pkg::ST_EMPTY;
                done_d = 1'b1;
              end else begin
                res_d = root_q;
                if (command_i == mpq_pkg::CMD_EXTRACT) begin
                  count_d = count_q - CNT_W'(1);
                  tot_d   = count_q - CNT_W'(1);
                  pos_d   = '0;
                  if (count_q == CNT_W'(1)) begin
                    done_d = 1'b1;
                  end else begin
                    // fetch the last entry to move to the root
                    ram_raddr_a = IDX_W'(count_q - CNT_W'(1));
                    state_d     = S_DN_LAST;
                  end
                end else begin
                  done_d = 1'b1;
                end
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Sift up: parent data is on read port A
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (val_q > ram_rdata_a) begin
          ram_waddr   = pos_q;
          ram_wdata   = ram_rdata_a;
          pos_d       = up_idx;
          ram_raddr_a = (up_idx - IDX_W'(1)) >> 1;
          if (up_idx == '0) begin
            state_d = S_UP_FIN;
          end
        end else begin
          ram_waddr = pos_q;
          ram_wdata = val_q;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_UP_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_DN_LAST: begin
        val_d   = ram_rdata_a;
        state_d = S_DN_RD;
      end

      // Sift down: fetch both children or settle the hole
      S_DN_RD: begin
        ram_raddr_a = IDX_W'(left_idx);
        ram_raddr_b = right_ok ? IDX_W'(right_idx) : IDX_W'(left_idx);
        if (left_ok) begin
          state_d = S_DN_CMP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = val_q;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_DN_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        if (child_val > val_q) begin
          ram_wdata = child_val;
          pos_d     = child_idx;
          state_d   = S_DN_RD;
        end else begin
          ram_wdata = val_q;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // keep the root mirror in step with RAM entry zero
    if (ram_we && ram_waddr == '0) begin
      root_d = ram_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cfg_q   <= mpq_pkg::CFG_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    val_q  <= val_d;
    root_q <= root_d;
    res_q  <= res_d;
    st_q   <= st_d;
    tot_q  <= tot_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = st_q;
  assign entry_total_o  = tot_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(mpq_pkg::HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result transfer while still busy");

  a_root_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_waddr == '0) |=> root_q == $past(ram_wdata))
    else $error("root mirror out of step with RAM");

  a_extract_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == mpq_pkg::CMD_EXTRACT && count_q != '0)
      |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("extract did not decrement count");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UP_CMP |-> pos_q != '0)
    else $error("sift up compare at the root");
`endif

endmodule

`default_nettype wire

// ===== hdl/mpq_ram.sv =====
`default_nettype none

// Generic RAM: one write port, two read ports, registered read data.
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output      logic [WIDTH-1:0]         rdata_a_o,
  output      logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire
